// ===== hdl/vwcp_pkg.sv =====
// shared types and constants for the variable width code packer
`default_nettype none
package vwcp_pkg;

	localparam int MAX_CODE_WIDTH   = 24;
	localparam int CODE_W           = 24;
	localparam int CW_W             = 5;
	localparam int BYTE_W           = 8;
	localparam int PEND_W           = 7;
	localparam int PCNT_W           = 3;
	localparam int ACC_W            = 32;
	localparam int NBITS_W          = 6;
	localparam int BYTES_PER_ENTRY  = 4;
	localparam int BCNT_W           = 3;
	localparam int BIDX_W           = 2;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QPTR_W           = 2;
	localparam int QCNT_W           = 3;
	localparam int ADDR_W           = 3;
	localparam int DATA_W           = 32;

	localparam logic [CW_W-1:0] CODE_WIDTH_RESET = 5'd12;

	// register index, taken from paddr above the byte offset
	localparam logic REG_CODE_WIDTH = 1'b0;

	// one queue entry: up to four bytes, left aligned, first byte in the top bits
	typedef struct packed {
		logic [ACC_W-1:0]  bytes;
		logic [BCNT_W-1:0] count;
		logic              last;
	} vwcp_entry_t;

	// queue status seen by the front
	typedef struct packed {
		logic full;
		logic empty;
	} vwcp_qstat_t;

endpackage
`default_nettype wire

// ===== hdl/variable_width_code_packer.sv =====
// top level of the msb-first variable width code packer
//
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   code_value[23:0], final_code
// out       output     out_valid / out_ready packed_byte[7:0], last_byte
// cfg       input      apb write/read        code_width at byte address 0
//
// a code is taken every cycle while the queue has room; bytes leave at one per cycle
// while out_ready is high, so a code that yields k bytes takes k byte transfers
// first byte of a code passes a queue slot and then the output register before it shows
// the output register and the four-entry group queue let the input keep moving
// while a byte waits on out_ready; no clearing pass after reset
// reset clears leftover bits, queue pointers, output valid and sets code_width to 12
`default_nettype none
module variable_width_code_packer (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// code input
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [vwcp_pkg::CODE_W-1:0]     code_value,
	input  wire logic                            final_code,
	// byte output
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [vwcp_pkg::BYTE_W-1:0]          packed_byte,
	output logic                                 last_byte,
	// configuration
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [vwcp_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [vwcp_pkg::DATA_W-1:0]     pwdata,
	output logic [vwcp_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready
);

	logic [vwcp_pkg::CW_W-1:0] code_width_q;
	logic                      reg_hit;

	vwcp_pkg::vwcp_qstat_t     qstat;
	vwcp_pkg::vwcp_entry_t     push_entry;
	vwcp_pkg::vwcp_entry_t     head;
	logic                      push;
	logic                      pop;

	// register file: one register, word index above the byte offset
	assign pready  = 1'b1;
	assign reg_hit = (paddr[vwcp_pkg::ADDR_W-1] == vwcp_pkg::REG_CODE_WIDTH);
	assign prdata  = reg_hit
		? {{(vwcp_pkg::DATA_W-vwcp_pkg::CW_W){1'b0}}, code_width_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_width_q <= vwcp_pkg::CODE_WIDTH_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			code_width_q <= pwdata[vwcp_pkg::CW_W-1:0];
		end
	end

	// front: merge code with leftover bits, emit byte groups
	vwcp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code_value (code_value),
		.final_code (final_code),
		.code_width (code_width_q),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	// decoupling queue
	vwcp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.qstat      (qstat),
		.pop        (pop),
		.head       (head)
	);

	// back: one byte per transfer
	vwcp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.packed_byte (packed_byte),
		.last_byte   (last_byte)
	);

endmodule
`default_nettype wire

// ===== hdl/vwcp_front.sv =====
// front end: takes codes, merges them with leftover bits and forms byte groups
`default_nettype none
module vwcp_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [vwcp_pkg::CODE_W-1:0]       code_value,
	input  wire logic                              final_code,
	input  wire logic [vwcp_pkg::CW_W-1:0]         code_width,
	input  wire vwcp_pkg::vwcp_qstat_t             qstat,
	output logic                                   push,
	output vwcp_pkg::vwcp_entry_t                  push_entry
);

	logic [vwcp_pkg::PEND_W-1:0]  pend_bits_q;
	logic [vwcp_pkg::PCNT_W-1:0]  pend_cnt_q;

	logic [vwcp_pkg::CW_W-1:0]    w_sat;
	logic [vwcp_pkg::CODE_W-1:0]  code_masked;
	logic [vwcp_pkg::ACC_W-1:0]   acc;
	logic [vwcp_pkg::ACC_W-1:0]   aligned;
	logic [vwcp_pkg::NBITS_W-1:0] nbits;
	logic [vwcp_pkg::NBITS_W-1:0] lshift;
	logic [vwcp_pkg::PCNT_W-1:0]  rem;
	logic [vwcp_pkg::BCNT_W-1:0]  cnt;
	logic                         accept;

	assign in_ready = ~qstat.full;
	assign accept   = in_valid & in_ready;

	// widths above the maximum saturate
	assign w_sat = (code_width > vwcp_pkg::CW_W'(vwcp_pkg::MAX_CODE_WIDTH))
		? vwcp_pkg::CW_W'(vwcp_pkg::MAX_CODE_WIDTH) : code_width;

	assign code_masked = code_value & ~({vwcp_pkg::CODE_W{1'b1}} << w_sat);
	assign acc = ({{(vwcp_pkg::ACC_W-vwcp_pkg::PEND_W){1'b0}}, pend_bits_q} << w_sat)
		| {{(vwcp_pkg::ACC_W-vwcp_pkg::CODE_W){1'b0}}, code_masked};
	assign nbits = {{(vwcp_pkg::NBITS_W-vwcp_pkg::PCNT_W){1'b0}}, pend_cnt_q}
		+ {{(vwcp_pkg::NBITS_W-vwcp_pkg::CW_W){1'b0}}, w_sat};

	// move the earliest bit to the top; an empty stream shifts out entirely
	assign lshift  = vwcp_pkg::NBITS_W'(vwcp_pkg::ACC_W) - nbits;
	assign aligned = acc << lshift;
	assign rem     = nbits[vwcp_pkg::PCNT_W-1:0];

	assign cnt = nbits[vwcp_pkg::NBITS_W-1:vwcp_pkg::PCNT_W]
		+ {{(vwcp_pkg::BCNT_W-1){1'b0}}, (final_code && rem != '0)};

	assign push_entry.bytes = aligned;
	assign push_entry.count = cnt;
	assign push_entry.last  = final_code && cnt != '0;
	// groups with no byte need no queue slot
	assign push = accept && cnt != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (accept) begin
			if (final_code) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
			end else begin
				pend_bits_q <= acc[vwcp_pkg::PEND_W-1:0]
					& ~({vwcp_pkg::PEND_W{1'b1}} << rem);
				pend_cnt_q  <= rem;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/vwcp_queue.sv =====
// short queue of byte groups between front and back
`default_nettype none
module vwcp_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire vwcp_pkg::vwcp_entry_t push_entry,
	output vwcp_pkg::vwcp_qstat_t      qstat,
	input  wire logic                  pop,
	output vwcp_pkg::vwcp_entry_t      head
);

	vwcp_pkg::vwcp_entry_t          slot_q [vwcp_pkg::QUEUE_DEPTH];
	logic [vwcp_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [vwcp_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [vwcp_pkg::QCNT_W-1:0]    fill_q;

	assign qstat.full  = (fill_q == vwcp_pkg::QCNT_W'(vwcp_pkg::QUEUE_DEPTH));
	assign qstat.empty = (fill_q == '0);
	assign head        = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/vwcp_back.sv =====
// back end: sends the bytes of each group, one per cycle unless out_ready stalls, through an output register
`default_nettype none
module vwcp_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire vwcp_pkg::vwcp_qstat_t        qstat,
	input  wire vwcp_pkg::vwcp_entry_t        head,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [vwcp_pkg::BYTE_W-1:0]       packed_byte,
	output logic                              last_byte
);

	logic [vwcp_pkg::BIDX_W-1:0] idx_q;
	logic                        out_valid_q;
	logic [vwcp_pkg::BYTE_W-1:0] byte_q;
	logic                        last_q;

	logic [vwcp_pkg::BYTE_W-1:0] sel_byte;
	logic                        end_of_group;
	logic                        load;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.bytes[31:24];
			2'd1:    sel_byte = head.bytes[23:16];
			2'd2:    sel_byte = head.bytes[15:8];
			default: sel_byte = head.bytes[7:0];
		endcase
	end

	assign end_of_group = ({1'b0, idx_q} + 1'b1) == head.count;
	assign load         = !qstat.empty && (!out_valid_q || out_ready);
	assign pop          = load && end_of_group;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= end_of_group ? '0 : idx_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= sel_byte;
			last_q <= head.last && end_of_group;
		end
	end

	assign out_valid   = out_valid_q;
	assign packed_byte = byte_q;
	assign last_byte   = last_q;

endmodule
`default_nettype wire

// ===== hdl/vwcp_checker.sv =====
// port level checks for the code packer, bound to the top level
`default_nettype none
module vwcp_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            out_valid,
	input  wire logic                            out_ready,
	input  wire logic [vwcp_pkg::BYTE_W-1:0]     packed_byte,
	input  wire logic                            last_byte,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [vwcp_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [vwcp_pkg::DATA_W-1:0]     pwdata,
	input  wire logic [vwcp_pkg::DATA_W-1:0]     prdata,
	input  wire logic                            pready
);

	// a stalled byte stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	// a stalled byte keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(packed_byte) && $stable(last_byte))
		else $error("output payload changed while stalled");

	// register read back returns the last write
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready
			&& paddr[vwcp_pkg::ADDR_W-1] == vwcp_pkg::REG_CODE_WIDTH
		|=> paddr[vwcp_pkg::ADDR_W-1] != vwcp_pkg::REG_CODE_WIDTH
			|| prdata[vwcp_pkg::CW_W-1:0] == $past(pwdata[vwcp_pkg::CW_W-1:0]))
		else $error("code_width read back differs from write");

	// unused register bits read as zero
	a_cfg_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pready && prdata[vwcp_pkg::DATA_W-1:vwcp_pkg::CW_W] == '0)
		else $error("register read has stray upper bits or wait state");

endmodule

bind variable_width_code_packer vwcp_checker u_vwcp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.packed_byte (packed_byte),
	.last_byte   (last_byte),
	.psel        (psel),
	.penable     (penable),
	.pwrite      (pwrite),
	.paddr       (paddr),
	.pwdata      (pwdata),
	.prdata      (prdata),
	.pready      (pready)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench for the variable width code packer
`timescale 1ns / 1ps

module tb_top;

	// ------------------------------------------------------------------
	// run shape
	// ------------------------------------------------------------------
	localparam int RAND_CODES    = 355;   // random codes after the directed table
	localparam int BURST_FROM    = 150;   // random codes in this window see no idling
	localparam int BURST_TO      = 230;
	localparam int SETTLE_CYCLES = 8;     // first byte passes a queue slot and the output register before it shows
	localparam int DIR_ROWS      = 25;

	// one byte leaving the packer
	typedef struct packed {
		logic [vwcp_pkg::BYTE_W-1:0] data;
		logic                        last;
	} out_byte_t;

	// one row of the directed table; exp_data holds up to four bytes, first byte on top,
	// and is only used where typed is set
	typedef struct packed {
		logic [vwcp_pkg::CW_W-1:0]   width;
		logic [vwcp_pkg::CODE_W-1:0] code;
		logic                        fin;
		logic                        typed;
		logic [2:0]                  n_exp;
		logic [31:0]                 exp_data;
	} stim_row_t;

	// ------------------------------------------------------------------
	// dut signals, all inputs known from time zero
	// ------------------------------------------------------------------
	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [vwcp_pkg::CODE_W-1:0] code_value = '0;
	logic                        final_code = 1'b0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [vwcp_pkg::BYTE_W-1:0] packed_byte;
	logic                        last_byte;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [vwcp_pkg::ADDR_W-1:0] paddr = '0;
	logic [vwcp_pkg::DATA_W-1:0] pwdata = '0;
	logic [vwcp_pkg::DATA_W-1:0] prdata;
	logic                        pready;

	// ------------------------------------------------------------------
	// packer model state and bookkeeping
	// ------------------------------------------------------------------
	logic [vwcp_pkg::CW_W-1:0]   width_reg = vwcp_pkg::CODE_WIDTH_RESET;   // mirrors code_width
	logic [vwcp_pkg::PEND_W-1:0] carry_bits = '0;   // leftover bits, right aligned
	logic [vwcp_pkg::PCNT_W-1:0] carry_cnt = '0;    // number of leftover bits

	out_byte_t due_bytes [$];   // bytes the packer still owes, oldest first

	int idle_pct = 32;          // chance in a hundred that a side idles this cycle
	int errors = 0;
	int n_codes = 0;
	int n_finals = 0;
	int n_bytes = 0;
	int n_width_writes = 0;

	variable_width_code_packer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.code_value  (code_value),
		.final_code  (final_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.packed_byte (packed_byte),
		.last_byte   (last_byte),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// 10 ns clock
	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	initial begin
		#2_000_000;
		$display("variable_width_code_packer verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// packer model: appends the low bits of one code msb first to the carry,
	// returns the number of bytes cut off, a padded final one included (first byte in bits 31:24)
	// ------------------------------------------------------------------
	function automatic int pack_code(input logic [vwcp_pkg::CODE_W-1:0] code, input logic fin,
			output logic [31:0] bytes_out);
		int          w;
		int          n;
		int          k;
		logic [31:0] acc;
		logic [31:0] tail;
		w = (int'(width_reg) > vwcp_pkg::MAX_CODE_WIDTH)
			? vwcp_pkg::MAX_CODE_WIDTH : int'(width_reg);
		acc = ({25'd0, carry_bits} << w) | ({8'd0, code} & ((32'd1 << w) - 32'd1));
		n = int'(carry_cnt) + w;
		k = 0;
		bytes_out = '0;
		// a byte goes out as soon as all eight of its bits are there
		while (n >= 8) begin
			bytes_out[31 - 8 * k -: 8] = acc[n - 1 -: 8];
			k++;
			n -= 8;
		end
		acc &= (32'd1 << n) - 32'd1;
		if (fin) begin
			// flush a partial byte, zero padded in its low bits
			if (n > 0) begin
				tail = acc << (8 - n);
				bytes_out[31 - 8 * k -: 8] = tail[7:0];
				k++;
			end
			carry_bits = '0;
			carry_cnt = '0;
		end else begin
			carry_bits = acc[vwcp_pkg::PEND_W-1:0];
			carry_cnt = n[vwcp_pkg::PCNT_W-1:0];
		end
		return k;
	endfunction

	// queue k bytes; only the closing byte of a stream carries last
	function automatic void owe_bytes(input logic [31:0] bytes, input int k, input logic fin);
		out_byte_t b;
		for (int i = 0; i < k; i++) begin
			b.data = bytes[31 - 8 * i -: 8];
			b.last = fin && (i == k - 1);
			due_bytes.push_back(b);
		end
	endfunction

	// ------------------------------------------------------------------
	// code channel: random gap, then hold valid until the transfer
	// ------------------------------------------------------------------
	task automatic send_code(input logic [vwcp_pkg::CODE_W-1:0] code, input logic fin);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		code_value <= code;
		final_code <= fin;
		do @(posedge clk); while (in_ready !== 1'b1);
		n_codes++;
		if (fin)
			n_finals++;
	endtask

	// transfer one code and queue what the model predicts for it
	task automatic push_code(input logic [vwcp_pkg::CODE_W-1:0] code, input logic fin);
		logic [31:0] bytes;
		int          k;
		send_code(code, fin);
		k = pack_code(code, fin, bytes);
		owe_bytes(bytes, k, fin);
	endtask

	// ------------------------------------------------------------------
	// code_width write: only once the packer has gone quiet, then read back
	// ------------------------------------------------------------------
	task automatic set_width(input logic [vwcp_pkg::DATA_W-1:0] wr_value);
		in_valid <= 1'b0;
		while (due_bytes.size() != 0)
			@(posedge clk);
		// a code can leave nothing owed while still in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
		// write: setup then access
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {vwcp_pkg::REG_CODE_WIDTH, 2'b00};
		pwdata  <= wr_value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		width_reg = wr_value[vwcp_pkg::CW_W-1:0];
		n_width_writes++;
		// read back straight from the write access
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== {{(vwcp_pkg::DATA_W-vwcp_pkg::CW_W){1'b0}}, width_reg}) begin
			$display("%0t: code_width read back expected %h actual %h",
				$time, {{(vwcp_pkg::DATA_W-vwcp_pkg::CW_W){1'b0}}, width_reg}, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// byte channel: random stalls, every transfer checked against the oldest owed byte
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_byte_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			n_bytes++;
			if (due_bytes.size() == 0) begin
				$display("%0t: unexpected byte expected none actual %h last %b",
					$time, packed_byte, last_byte);
				errors++;
			end else begin
				want = due_bytes.pop_front();
				if (packed_byte !== want.data) begin
					$display("%0t: packed_byte expected %h actual %h",
						$time, want.data, packed_byte);
					errors++;
				end
				if (last_byte !== want.last) begin
					$display("%0t: last_byte expected %b actual %b",
						$time, want.last, last_byte);
					errors++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		stim_row_t                   rows [DIR_ROWS];
		logic [31:0]                 bytes;
		logic [vwcp_pkg::CW_W-1:0]   w;
		logic [vwcp_pkg::CODE_W-1:0] code;
		logic                        fin;
		int                          k;
		int                          sent;
		int                          phase_len;

		// directed table: width, code, final, typed, byte count, bytes
		rows = '{
			// reset width of 12, then a stream ending on a byte edge
			'{5'd12, 24'h000ABC, 1'b0, 1'b1, 3'd1, 32'hAB00_0000},
			'{5'd12, 24'h000FFF, 1'b1, 1'b1, 3'd2, 32'hCFFF_0000},
			// widest code, all ones then all zeros
			'{5'd24, 24'hFFFFFF, 1'b0, 1'b1, 3'd3, 32'hFFFF_FF00},
			'{5'd24, 24'h000000, 1'b1, 1'b1, 3'd3, 32'h0000_0000},
			// narrowest code, padded flush
			'{5'd1,  24'h000001, 1'b1, 1'b1, 3'd1, 32'h8000_0000},
			// zero width final with nothing pending sends nothing
			'{5'd0,  24'hFFFFFF, 1'b1, 1'b1, 3'd0, 32'h0000_0000},
			// three bits left over, zero width adds none, zero width final flushes them
			'{5'd3,  24'hFFFFFD, 1'b0, 1'b1, 3'd0, 32'h0000_0000},
			'{5'd0,  24'hFFFFFF, 1'b0, 1'b1, 3'd0, 32'h0000_0000},
			'{5'd0,  24'h000000, 1'b1, 1'b1, 3'd1, 32'hA000_0000},
			// widths above the maximum saturate to 24
			'{5'd31, 24'hFFFFFF, 1'b1, 1'b1, 3'd3, 32'hFFFF_FF00},
			'{5'd25, 24'h123456, 1'b0, 1'b1, 3'd3, 32'h1234_5600},
			// seven bits carried into a widest final code: four bytes
			'{5'd7,  24'hFFFF7F, 1'b0, 1'b1, 3'd0, 32'h0000_0000},
			'{5'd24, 24'hFFFFFF, 1'b1, 1'b1, 3'd4, 32'hFFFF_FFFE},
			// the rest goes through the model
			'{5'd7,  24'h00007F, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
			'{5'd7,  24'h000000, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
			'{5'd7,  24'h000055, 1'b1, 1'b0, 3'd0, 32'h0000_0000},
			'{5'd9,  24'h0001FF, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
			'{5'd9,  24'hFFFE00, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
			'{5'd9,  24'h000155, 1'b1, 1'b0, 3'd0, 32'h0000_0000},
			'{5'd8,  24'h0000A5, 1'b1, 1'b0, 3'd0, 32'h0000_0000},
			// bits above the width are ignored
			'{5'd16, 24'hABFFFF, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
			'{5'd16, 24'h540000, 1'b1, 1'b0, 3'd0, 32'h0000_0000},
			'{5'd5,  24'h00001F, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
			'{5'd5,  24'h000000, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
			'{5'd23, 24'h7FFFFF, 1'b1, 1'b0, 3'd0, 32'h0000_0000}
		};

		// reset held from time zero, released on a rising edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: a width change waits for the packer to drain
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (rows[i].width != width_reg)
				set_width({27'd0, rows[i].width});
			send_code(rows[i].code, rows[i].fin);
			k = pack_code(rows[i].code, rows[i].fin, bytes);
			if (rows[i].typed)
				owe_bytes(rows[i].exp_data, int'(rows[i].n_exp), rows[i].fin);
			else
				owe_bytes(bytes, k, rows[i].fin);
		end

		// random part: phases of one width, streams of random codes in each
		sent = 0;
		while (sent < RAND_CODES) begin
			case ($urandom_range(7))
				0: begin
					case ($urandom_range(3))
						0: w = 5'd0;
						1: w = 5'd1;
						2: w = 5'd24;
						default: w = 5'd31;
					endcase
				end
				1: w = 5'($urandom_range(25, 31));
				default: w = 5'($urandom_range(1, 24));
			endcase
			// junk in the unused upper bits of pwdata
			set_width(($urandom & 32'hFFFF_FFE0) | {27'd0, w});
			phase_len = $urandom_range(8, 30);
			for (int j = 0; j < phase_len; j++) begin
				case ($urandom_range(9))
					0: code = '0;
					1: code = '1;
					default: code = vwcp_pkg::CODE_W'($urandom);
				endcase
				// most streams close within the phase, some run across a width change
				fin = ($urandom_range(5) == 0) || (j == phase_len - 1 && $urandom_range(1));
				idle_pct = (sent >= BURST_FROM && sent < BURST_TO) ? 0 : 32;
				push_code(code, fin);
				// zero width codes that do not close a stream move nothing
				if (w != 5'd0 || fin)
					sent++;
			end
		end

		// close the last stream so nothing is left in the carry
		idle_pct = 32;
		push_code(vwcp_pkg::CODE_W'($urandom), 1'b1);
		in_valid <= 1'b0;

		// drain, then give the packer time to show anything extra
		while (due_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (due_bytes.size() != 0) begin
			$display("%0t: %0d bytes never arrived", $time, due_bytes.size());
			errors++;
		end

		$display("run covered %0d codes in %0d streams over %0d code_width writes",
			n_codes, n_finals, n_width_writes);
		$display("%0d bytes checked, %0d errors", n_bytes, errors);
		if (errors == 0)
			$display("variable_width_code_packer verification clean");
		else
			$display("variable_width_code_packer verification failed");
		$finish;
	end

endmodule

// ===== variable_width_code_packer.f =====
hdl/vwcp_pkg.sv
hdl/vwcp_front.sv
hdl/vwcp_queue.sv
hdl/vwcp_back.sv
hdl/variable_width_code_packer.sv
hdl/vwcp_checker.sv
sim/tb_top.sv
